[rtl/section_table_address_translate_macros.svh]
// Assertion macros shared by the checker of the section table translator.
`ifndef SECTION_TABLE_ADDRESS_TRANSLATE_MACROS_SVH
`define SECTION_TABLE_ADDRESS_TRANSLATE_MACROS_SVH

// Same-cycle implication, clocked on i_clk and quiet while i_rst_n is low.
`define STAT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("section table check failed");

// Next-cycle implication, clocked on i_clk and quiet while i_rst_n is low.
`define STAT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("section table check failed");

`endif

[rtl/stat_pkg.sv]
// ----------------------------------------------------------------------------
// stat_pkg
// Types and constants of the section table address translator.
// ----------------------------------------------------------------------------
package stat_pkg;

    // Table depth and the widths that follow from it.
    localparam int MAX_REGIONS = 16;
    localparam int REG_ADDR_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int REG_CNT_W   = $clog2(MAX_REGIONS + 1);

    // Fixed field widths.
    localparam int WORD_W      = 32;
    localparam int ENTRY_IDX_W = 4;
    localparam int LOG2_W      = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SECTIONS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_BASE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIRTUAL_ALIGN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_ALIGN       = 2'd3;

    // Reset values of the alignment registers.
    localparam logic [LOG2_W-1:0] VIRTUAL_ALIGN_RESET = 5'd12;
    localparam logic [LOG2_W-1:0] RAW_ALIGN_RESET     = 5'd9;

    // Operation codes of an input beat.
    typedef enum logic [1:0] {
        OP_WRITE     = 2'd0,
        OP_XLATE_REL = 2'd1,
        OP_XLATE_ABS = 2'd2,
        OP_FIND      = 2'd3
    } t_op;

    // One table entry as stored in the region memory.
    typedef struct packed {
        logic [WORD_W-1:0] vstart;
        logic [WORD_W-1:0] vsize;
        logic [WORD_W-1:0] rstart;
        logic [WORD_W-1:0] rsize;
    } t_region;

    localparam int REGION_W = $bits(t_region);

endpackage

[rtl/stat_stream_if.sv]
// ----------------------------------------------------------------------------
// stat_req_if / stat_rsp_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface stat_req_if;
    import stat_pkg::*;

    logic                   valid;
    logic                   ready;
    t_op                    op;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [WORD_W-1:0]      address;
    logic [WORD_W-1:0]      entry_virtual_start;
    logic [WORD_W-1:0]      entry_virtual_size;
    logic [WORD_W-1:0]      entry_raw_start;
    logic [WORD_W-1:0]      entry_raw_size;

    modport source (
        output valid, op, entry_index, address, entry_virtual_start,
               entry_virtual_size, entry_raw_start, entry_raw_size,
        input  ready
    );
    modport sink (
        input  valid, op, entry_index, address, entry_virtual_start,
               entry_virtual_size, entry_raw_start, entry_raw_size,
        output ready
    );
endinterface

interface stat_rsp_if;
    import stat_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   found;
    logic [ENTRY_IDX_W-1:0] region_index;
    logic [WORD_W-1:0]      raw_offset;

    modport source (
        output valid, found, region_index, raw_offset,
        input  ready
    );
    modport sink (
        input  valid, found, region_index, raw_offset,
        output ready
    );
endinterface

[rtl/stat_ram.sv]
// ----------------------------------------------------------------------------
// stat_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module stat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/section_table_address_translate.sv]
// A write beat gives its result in the cycle after acceptance. A query scans the first N
// entries in order, N = min(active_sections, MAX_REGIONS), and stops at the first hit;
// each entry passes the table read register and the aligned-size stage before the test.
// Throughput: one beat at a time; the scan reads one table entry per cycle through
// the single read port of the region memory.
// Reset (synchronous, i_rst_n low) resets sequencer and config; the table is not cleared.
// ----------------------------------------------------------------------------
// section_table_address_translate
// Region table with ordered first-match lookup of virtual and raw addresses.
// ----------------------------------------------------------------------------
module section_table_address_translate (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [stat_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [stat_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    stat_req_if.sink                           i_in,
    stat_rsp_if.source                         o_out
);
    import stat_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    // Sequencer and configuration state.
    t_state                  r_state, n_state;
    logic [LOG2_W-1:0]       r_active;
    logic [WORD_W-1:0]       r_base;
    logic [LOG2_W-1:0]       r_valign;
    logic [LOG2_W-1:0]       r_ralign;

    // Query context.
    logic                    r_find, n_find;
    logic [WORD_W-1:0]       r_addr, n_addr;
    logic [REG_CNT_W-1:0]    r_limit, n_limit;
    logic [REG_CNT_W-1:0]    r_rd_cnt, n_rd_cnt;

    // Scan pipeline: read data stage and aligned-size stage.
    logic                    r_v1, n_v1;
    logic [REG_ADDR_W-1:0]   r_idx1, n_idx1;
    logic                    r_v2, n_v2;
    logic [REG_ADDR_W-1:0]   r_idx2, n_idx2;
    logic [WORD_W-1:0]       r_start2, n_start2;
    logic [WORD_W-1:0]       r_asize2, n_asize2;
    logic [WORD_W-1:0]       r_diff2, n_diff2;
    logic [WORD_W-1:0]       r_rstart2, n_rstart2;

    // Output register.
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_found, n_out_found;
    logic [ENTRY_IDX_W-1:0]  r_out_index, n_out_index;
    logic [WORD_W-1:0]       r_out_offset, n_out_offset;

    // Combinational helpers.
    logic                    in_ready;
    logic                    in_accept;
    logic                    tbl_we;
    logic [REG_ADDR_W-1:0]   tbl_waddr;
    t_region                 tbl_wdata;
    t_region                 tbl_rdata;
    logic [WORD_W-1:0]       sel_start;
    logic [WORD_W-1:0]       sel_size;
    logic [WORD_W-1:0]       align_mask;
    logic [WORD_W-1:0]       span_end;
    logic                    hit;
    logic                    issue;
    logic                    miss;
    logic [WORD_W-1:0]       xlate_offset;

    // Input handshake: one beat at a time, and only when the result slot is free.
    assign in_ready  = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign in_accept = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    // Table write path.
    assign tbl_we    = in_accept && (i_in.op == OP_WRITE)
                       && (32'(i_in.entry_index) < 32'(MAX_REGIONS));
    assign tbl_waddr = REG_ADDR_W'(i_in.entry_index);
    assign tbl_wdata = '{vstart: i_in.entry_virtual_start,
                         vsize:  i_in.entry_virtual_size,
                         rstart: i_in.entry_raw_start,
                         rsize:  i_in.entry_raw_size};

    stat_ram #(
        .WIDTH (REGION_W),
        .DEPTH (MAX_REGIONS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (r_rd_cnt[REG_ADDR_W-1:0]),
        .o_rdata (tbl_rdata)
    );

    // First stage: pick the span fields and round the size up.
    always_comb begin
        sel_start  = r_find ? tbl_rdata.rstart : tbl_rdata.vstart;
        sel_size   = r_find ? tbl_rdata.rsize  : tbl_rdata.vsize;
        align_mask = ~({WORD_W{1'b1}} << (r_find ? r_ralign : r_valign));
    end

    // Second stage: span end, containment test and translated offset.
    assign span_end     = r_start2 + r_asize2;
    assign hit          = r_v2 && (r_addr >= r_start2) && (r_addr < span_end);
    assign xlate_offset = r_diff2 + r_rstart2;
    assign issue        = (r_rd_cnt < r_limit) && !hit;
    assign miss         = (r_rd_cnt >= r_limit) && !r_v1 && !hit;

    // Sequencer and datapath next values.
    always_comb begin
        n_state      = r_state;
        n_find       = r_find;
        n_addr       = r_addr;
        n_limit      = r_limit;
        n_rd_cnt     = r_rd_cnt;
        n_v1         = 1'b0;
        n_idx1       = r_idx1;
        n_v2         = 1'b0;
        n_idx2       = r_idx2;
        n_start2     = r_start2;
        n_asize2     = r_asize2;
        n_diff2      = r_diff2;
        n_rstart2    = r_rstart2;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_found  = r_out_found;
        n_out_index  = r_out_index;
        n_out_offset = r_out_offset;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_in.op == OP_WRITE) begin
                        n_out_valid  = 1'b1;
                        n_out_found  = 1'b0;
                        n_out_index  = '0;
                        n_out_offset = '0;
                    end else begin
                        n_state  = S_SCAN;
                        n_find   = (i_in.op == OP_FIND);
                        n_addr   = (i_in.op == OP_XLATE_ABS) ? (i_in.address - r_base)
                                                             : i_in.address;
                        n_limit  = (32'(r_active) > 32'(MAX_REGIONS))
                                   ? REG_CNT_W'(MAX_REGIONS) : REG_CNT_W'(r_active);
                        n_rd_cnt = '0;
                    end
                end
            end
            S_SCAN: begin
                // Issue the next entry read.
                if (issue) begin
                    n_v1     = 1'b1;
                    n_idx1   = r_rd_cnt[REG_ADDR_W-1:0];
                    n_rd_cnt = r_rd_cnt + 1'b1;
                end
                // Advance the read data into the aligned-size stage.
                n_v2      = r_v1 && !hit;
                n_idx2    = r_idx1;
                n_start2  = sel_start;
                n_asize2  = (sel_size + align_mask) & ~align_mask;
                n_diff2   = r_addr - tbl_rdata.vstart;
                n_rstart2 = tbl_rdata.rstart;
                // Finish on the first hit, or once every entry missed.
                if (hit || miss) begin
                    n_state      = S_IDLE;
                    n_v1         = 1'b0;
                    n_v2         = 1'b0;
                    n_out_valid  = 1'b1;
                    n_out_found  = hit;
                    n_out_index  = hit ? ENTRY_IDX_W'(r_idx2) : '0;
                    n_out_offset = (hit && !r_find) ? xlate_offset : '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= '0;
            r_base      <= '0;
            r_valign    <= VIRTUAL_ALIGN_RESET;
            r_ralign    <= RAW_ALIGN_RESET;
        end else begin
            r_state     <= n_state;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ACTIVE_SECTIONS: r_active <= i_cfg_data[LOG2_W-1:0];
                    CFG_IMAGE_BASE:      r_base   <= i_cfg_data[WORD_W-1:0];
                    CFG_VIRTUAL_ALIGN:   r_valign <= i_cfg_data[LOG2_W-1:0];
                    CFG_RAW_ALIGN:       r_ralign <= i_cfg_data[LOG2_W-1:0];
                    default: begin
                        r_active <= r_active;
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_find       <= n_find;
        r_addr       <= n_addr;
        r_limit      <= n_limit;
        r_rd_cnt     <= n_rd_cnt;
        r_idx1       <= n_idx1;
        r_idx2       <= n_idx2;
        r_start2     <= n_start2;
        r_asize2     <= n_asize2;
        r_diff2      <= n_diff2;
        r_rstart2    <= n_rstart2;
        r_out_found  <= n_out_found;
        r_out_index  <= n_out_index;
        r_out_offset <= n_out_offset;
    end

    // Result beat.
    assign o_out.valid        = r_out_valid;
    assign o_out.found        = r_out_found;
    assign o_out.region_index = r_out_index;
    assign o_out.raw_offset   = r_out_offset;
endmodule

[rtl/stat_checker.sv]
// ----------------------------------------------------------------------------
// stat_checker
// Port-level checks of the section table translator, bound to its top level.
// ----------------------------------------------------------------------------
`include "section_table_address_translate_macros.svh"

module stat_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  stat_pkg::t_op                   i_in_op,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic                            i_out_found,
    input  logic [stat_pkg::ENTRY_IDX_W-1:0] i_out_region_index,
    input  logic [stat_pkg::WORD_W-1:0]     i_out_raw_offset
);
    import stat_pkg::*;

    logic write_accept;
    logic query_accept;
    logic empty_result;

    // Accepted input beats by kind, and an all-zero result payload.
    assign write_accept = i_in_valid && i_in_ready && (i_in_op == OP_WRITE);
    assign query_accept = i_in_valid && i_in_ready && (i_in_op != OP_WRITE);
    assign empty_result = !i_out_found && (i_out_region_index == '0)
                          && (i_out_raw_offset == '0);

    // A result beat that is not taken stays offered.
    `STAT_ASSERT_NEXT(a_out_held, i_out_valid && !i_out_ready, i_out_valid)

    // A write beat is answered in the next cycle with an empty result.
    `STAT_ASSERT_NEXT(a_write_result, write_accept, i_out_valid && empty_result)

    // A query beat keeps the input closed while the table is scanned.
    `STAT_ASSERT_NEXT(a_query_busy, query_accept, !i_in_ready)

    // No new beat is taken while a finished result is still stalled.
    `STAT_ASSERT_NOW(a_stall_blocks, i_out_valid && !i_out_ready, !i_in_ready)
endmodule

bind section_table_address_translate stat_checker u_stat_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_in_op            (i_in.op),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_found        (o_out.found),
    .i_out_region_index (o_out.region_index),
    .i_out_raw_offset   (o_out.raw_offset)
);

[bench/tb_section_table_address_translate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_section_table_address_translate
// Self-checking bench for the section table translator. Table loads, virtual
// and raw lookups are sent over the request channel, mostly with random gaps, and each
// result beat is compared with a local model of the table and its registers.
// ----------------------------------------------------------------------------
module tb_section_table_address_translate;
    import stat_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_COUNT  = 17;
    localparam int PHASE_ITEMS  = 100;
    localparam int DRAIN_CYCLES = 24;

    // One request beat as the bench builds it.
    typedef struct {
        t_op                    op;
        logic [ENTRY_IDX_W-1:0] entry_index;
        logic [WORD_W-1:0]      address;
        t_region                region;
    } t_lookup_beat;

    // One result beat.
    typedef struct packed {
        logic                   found;
        logic [ENTRY_IDX_W-1:0] region_index;
        logic [WORD_W-1:0]      raw_offset;
    } t_xlate_result;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    stat_req_if lookup_if ();
    stat_rsp_if result_if ();

    section_table_address_translate DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (lookup_if),
        .o_out      (result_if)
    );

    // Local copy of the table and the registers.
    t_region                region_shadow [MAX_REGIONS];
    logic [REG_CNT_W-1:0]   active_shadow;
    logic [WORD_W-1:0]      base_shadow;
    logic [LOG2_W-1:0]      valign_shadow;
    logic [LOG2_W-1:0]      ralign_shadow;

    t_xlate_result pending_results [$];
    int            mismatch_cnt = 0;
    int unsigned   cycle_cnt    = 0;
    bit            gaps_on      = 1'b0;

    always #(CLK_HALF) i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Size rounded up to a power-of-two alignment, wrapping at 32 bits.
    function automatic logic [WORD_W-1:0] aligned_size(logic [WORD_W-1:0] size,
                                                       logic [LOG2_W-1:0] lg);
        logic [WORD_W-1:0] mask;
        mask = (32'd1 << lg) - 32'd1;
        return (size + mask) & ~mask;
    endfunction

    // First entry whose virtual or raw span holds the address, or -1.
    function automatic int first_region_hit(logic [WORD_W-1:0] addr, bit raw_side);
        int                n;
        logic [WORD_W-1:0] span_lo;
        logic [WORD_W-1:0] span_hi;
        n = (active_shadow > MAX_REGIONS) ? MAX_REGIONS : int'(active_shadow);
        for (int i = 0; i < n; i++) begin
            if (raw_side) begin
                span_lo = region_shadow[i].rstart;
                span_hi = span_lo + aligned_size(region_shadow[i].rsize, ralign_shadow);
            end else begin
                span_lo = region_shadow[i].vstart;
                span_hi = span_lo + aligned_size(region_shadow[i].vsize, valign_shadow);
            end
            if (addr >= span_lo && addr < span_hi)
                return i;
        end
        return -1;
    endfunction

    // Result of one accepted beat; a write beat also updates the table copy.
    function automatic t_xlate_result translate_beat(t_lookup_beat b);
        t_xlate_result     res;
        logic [WORD_W-1:0] rva;
        int                hit;
        res = '0;
        case (b.op)
            OP_WRITE: begin
                region_shadow[b.entry_index] = b.region;
            end
            OP_FIND: begin
                hit = first_region_hit(b.address, 1'b1);
                if (hit >= 0) begin
                    res.found        = 1'b1;
                    res.region_index = hit[ENTRY_IDX_W-1:0];
                end
            end
            default: begin
                rva = (b.op == OP_XLATE_ABS) ? b.address - base_shadow : b.address;
                hit = first_region_hit(rva, 1'b0);
                if (hit >= 0) begin
                    res.found        = 1'b1;
                    res.region_index = hit[ENTRY_IDX_W-1:0];
                    res.raw_offset   = rva - region_shadow[hit].vstart
                                       + region_shadow[hit].rstart;
                end
            end
        endcase
        return res;
    endfunction

    // Send one request beat, after a random gap while gaps are on, and record its result.
    task automatic send_beat(t_lookup_beat b);
        int gap;
        gap = gaps_on ? $urandom_range(0, 10) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            lookup_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        lookup_if.op                  = b.op;
        lookup_if.entry_index         = b.entry_index;
        lookup_if.address             = b.address;
        lookup_if.entry_virtual_start = b.region.vstart;
        lookup_if.entry_virtual_size  = b.region.vsize;
        lookup_if.entry_raw_start     = b.region.rstart;
        lookup_if.entry_raw_size      = b.region.rsize;
        lookup_if.valid               = 1'b1;
        do @(posedge i_clk); while (!lookup_if.ready);
        pending_results.push_back(translate_beat(b));
    endtask

    // Drop valid and wait until every result has come back.
    task automatic wait_idle();
        @(negedge i_clk);
        lookup_if.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write one register; only called while the block is idle.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_ACTIVE_SECTIONS: active_shadow = data[REG_CNT_W-1:0];
            CFG_IMAGE_BASE:      base_shadow   = data;
            CFG_VIRTUAL_ALIGN:   valign_shadow = data[LOG2_W-1:0];
            CFG_RAW_ALIGN:       ralign_shadow = data[LOG2_W-1:0];
            default: ;
        endcase
    endtask

    // A 5-bit register value with random bits above it.
    function automatic logic [CFG_DATA_W-1:0] narrow_value(int unsigned value);
        logic [CFG_DATA_W-1:0] data;
        data       = $urandom;
        data[4:0]  = value[4:0];
        return data;
    endfunction

    function automatic t_lookup_beat entry_beat(logic [ENTRY_IDX_W-1:0] idx,
                                                logic [WORD_W-1:0] vs, logic [WORD_W-1:0] vsz,
                                                logic [WORD_W-1:0] rs, logic [WORD_W-1:0] rsz);
        t_lookup_beat b;
        b.op          = OP_WRITE;
        b.entry_index = idx;
        b.address     = $urandom;
        b.region      = '{vstart: vs, vsize: vsz, rstart: rs, rsize: rsz};
        return b;
    endfunction

    function automatic t_lookup_beat query_beat(t_op op, logic [WORD_W-1:0] addr);
        t_lookup_beat b;
        b.op          = op;
        b.entry_index = ENTRY_IDX_W'($urandom);
        b.address     = addr;
        b.region      = '{vstart: $urandom, vsize: $urandom,
                          rstart: $urandom, rsize: $urandom};
        return b;
    endfunction

    // Region contents: mostly an image-like layout, some fully random or near the top.
    function automatic t_region random_region();
        t_region r;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                r.vstart = 32'h1000 * $urandom_range(0, 48);
                r.vsize  = $urandom_range(0, 32'h4000);
                r.rstart = 32'h200 * $urandom_range(0, 96);
                r.rsize  = $urandom_range(0, 32'h3000);
            end
            6, 7: begin
                r = '{vstart: $urandom, vsize: $urandom, rstart: $urandom, rsize: $urandom};
            end
            default: begin
                r.vstart = 32'hFFFF_0000 | $urandom_range(0, 32'hFFFF);
                r.vsize  = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF
                                                       : $urandom_range(0, 32'h2000);
                r.rstart = 32'hFFFF_F000 | $urandom_range(0, 32'hFFF);
                r.rsize  = ($urandom_range(0, 1) != 0) ? 32'h0 : $urandom_range(0, 32'h1000);
            end
        endcase
        return r;
    endfunction

    // Random beat; lookups aim at span edges of a table entry most of the time.
    function automatic t_lookup_beat random_beat();
        t_lookup_beat      b;
        int                j;
        int                n;
        bit                raw_side;
        logic [WORD_W-1:0] span_lo;
        logic [WORD_W-1:0] span_len;
        if ($urandom_range(0, 99) < 15) begin
            b = entry_beat(ENTRY_IDX_W'($urandom), 0, 0, 0, 0);
            b.region = random_region();
            return b;
        end
        b = query_beat(t_op'($urandom_range(1, 3)), $urandom);
        n = (active_shadow > MAX_REGIONS) ? MAX_REGIONS : int'(active_shadow);
        j = (n > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, n - 1)
                                                  : $urandom_range(0, MAX_REGIONS - 1);
        raw_side = (b.op == OP_FIND);
        span_lo  = raw_side ? region_shadow[j].rstart : region_shadow[j].vstart;
        span_len = raw_side ? aligned_size(region_shadow[j].rsize, ralign_shadow)
                            : aligned_size(region_shadow[j].vsize, valign_shadow);
        case ($urandom_range(0, 5))
            0: b.address = span_lo;
            1: b.address = span_lo + span_len - 1;
            2: b.address = span_lo + span_len;
            3: b.address = span_lo - 1;
            4: b.address = span_lo + ((span_len != 0) ? $urandom % span_len : 0);
            default: ;
        endcase
        if (b.op == OP_XLATE_ABS)
            b.address = b.address + base_shadow;
        return b;
    endfunction

    // After reset nothing is searched, so every lookup misses.
    task automatic test_reset_state();
        send_beat(query_beat(OP_XLATE_REL, 32'h0000_1000));
        send_beat(query_beat(OP_FIND, 32'h0000_0000));
        send_beat(query_beat(OP_XLATE_ABS, 32'hFFFF_FFFF));
        wait_idle();
    endtask

    // Hand-built table: rounding, exact sizes, wrapping spans, overlap order.
    task automatic test_directed_table();
        send_beat(entry_beat(4'd0, 32'h0000_1000, 32'h1, 32'h0000_0400, 32'h1));
        send_beat(entry_beat(4'd1, 32'h0000_2000, 32'h2000, 32'h0000_0600, 32'h200));
        send_beat(entry_beat(4'd2, 32'hFFFF_F000, 32'h1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_beat(entry_beat(4'd3, 32'h0000_1800, 32'h100, 32'h0000_0000, 32'h200));
        send_beat(entry_beat(4'd15, '1, '1, '1, '1));
        wait_idle();
        write_register(CFG_ACTIVE_SECTIONS, 32'd4);
        write_register(CFG_IMAGE_BASE, 32'h0040_0000);
        // Virtual side, default alignment of 4 KiB.
        send_beat(query_beat(OP_XLATE_REL, 32'h0000_1000));
        send_beat(query_beat(OP_XLATE_REL, 32'h0000_1FFF));
        send_beat(query_beat(OP_XLATE_REL, 32'h0000_2000));
        send_beat(query_beat(OP_XLATE_REL, 32'h0000_0FFF));
        send_beat(query_beat(OP_XLATE_REL, 32'h0000_1800));
        send_beat(query_beat(OP_XLATE_REL, 32'hFFFF_F800));
        send_beat(query_beat(OP_XLATE_ABS, 32'h0040_1000));
        send_beat(query_beat(OP_XLATE_ABS, 32'h0000_0000));
        // Raw side, default alignment of 512 bytes; the offset stays zero.
        send_beat(query_beat(OP_FIND, 32'h0000_0400));
        send_beat(query_beat(OP_FIND, 32'h0000_05FF));
        send_beat(query_beat(OP_FIND, 32'h0000_0600));
        send_beat(query_beat(OP_FIND, 32'h0000_0000));
        wait_idle();
    endtask

    // Settings for one random phase; the first three are fixed corner cases.
    task automatic random_settings(int phase);
        int unsigned       act;
        logic [WORD_W-1:0] base;
        int unsigned       va;
        int unsigned       ra;
        case (phase)
            0: begin act = 16; base = '0;            va = 0;  ra = 0;  end
            1: begin act = 31; base = '1;            va = 31; ra = 31; end
            2: begin act = 17; base = 32'h0040_0000; va = 12; ra = 9;  end
            default: begin
                act  = $urandom_range(0, 31);
                base = ($urandom_range(0, 1) != 0) ? 32'h0040_0000 : $urandom;
                va   = ($urandom_range(0, 2) == 0) ? 12 : $urandom_range(0, 31);
                ra   = ($urandom_range(0, 2) == 0) ? 9 : $urandom_range(0, 31);
            end
        endcase
        write_register(CFG_ACTIVE_SECTIONS, narrow_value(act));
        write_register(CFG_IMAGE_BASE, base);
        write_register(CFG_VIRTUAL_ALIGN, narrow_value(va));
        write_register(CFG_RAW_ALIGN, narrow_value(ra));
        gaps_on = (phase % 4) != 3;
    endtask

    // Load the full table, then run random phases under changing settings.
    task automatic test_random_traffic();
        t_lookup_beat b;
        gaps_on = 1'b1;
        for (int i = 0; i < MAX_REGIONS; i++) begin
            b = entry_beat(i[ENTRY_IDX_W-1:0], 0, 0, 0, 0);
            b.region = random_region();
            send_beat(b);
        end
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_idle();
            random_settings(phase);
            repeat (PHASE_ITEMS) send_beat(random_beat());
        end
        wait_idle();
    endtask

    // Result side: random stall before each beat while gaps are on.
    initial begin
        int stall;
        result_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = gaps_on ? $urandom_range(0, 10) : 0;
            repeat (stall) begin
                @(negedge i_clk);
                result_if.ready = 1'b0;
            end
            @(negedge i_clk);
            result_if.ready = 1'b1;
            do @(posedge i_clk); while (!result_if.valid);
        end
    end

    // Compare each result beat with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_xlate_result predicted;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no lookup pending");
                mismatch_cnt++;
            end else begin
                predicted = pending_results.pop_front();
                if (result_if.found !== predicted.found) begin
                    $error("found: expected %0d, actual %0d",
                           predicted.found, result_if.found);
                    mismatch_cnt++;
                end
                if (result_if.region_index !== predicted.region_index) begin
                    $error("region_index: expected %0d, actual %0d",
                           predicted.region_index, result_if.region_index);
                    mismatch_cnt++;
                end
                if (result_if.raw_offset !== predicted.raw_offset) begin
                    $error("raw_offset: expected 0x%08h, actual 0x%08h",
                           predicted.raw_offset, result_if.raw_offset);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Test sequence.
    initial begin
        lookup_if.valid               = 1'b0;
        lookup_if.op                  = OP_WRITE;
        lookup_if.entry_index         = '0;
        lookup_if.address             = '0;
        lookup_if.entry_virtual_start = '0;
        lookup_if.entry_virtual_size  = '0;
        lookup_if.entry_raw_start     = '0;
        lookup_if.entry_raw_size      = '0;
        active_shadow  = '0;
        base_shadow    = '0;
        valign_shadow  = VIRTUAL_ALIGN_RESET;
        ralign_shadow  = RAW_ALIGN_RESET;
        for (int i = 0; i < MAX_REGIONS; i++)
            region_shadow[i] = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_directed_table();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[section_table_address_translate.f]
+incdir+rtl
rtl/stat_pkg.sv
rtl/stat_stream_if.sv
rtl/stat_ram.sv
rtl/section_table_address_translate.sv
rtl/stat_checker.sv
bench/tb_section_table_address_translate.sv
